[hdl/kte_pkg.sv]
// Shared types, constants and the key lookup table for the key to
// escape sequence encoder. No dependencies.
`default_nettype none

package kte_pkg;

  localparam int SEQ_MAX = 7;               // longest sequence: ESC [ 2 4 ; 8 ~
  localparam int LEN_W   = $clog2(SEQ_MAX + 1);

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_SS3   = 8'h4F;  // 'O'

  localparam logic [4:0] KEY_BACKSPACE = 5'd1;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_BYTE,
    KIND_SHORT,
    KIND_NUMBER
  } kind_t;

  // a: single byte or c0 of the short form; b: final letter or key number
  typedef struct packed {
    kind_t      kind;
    logic [7:0] a;
    logic [7:0] b;
  } key_entry_t;

  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;
    logic [LEN_W-1:0]        len;
  } seq_t;

  function automatic key_entry_t key_lookup(input logic [4:0] code);
    key_entry_t e;
    e = '{KIND_NONE, 8'h00, 8'h00};
    case (code)
      5'd0:  e = '{KIND_BYTE, CH_CR, 8'h00};
      5'd1:  e = '{KIND_BYTE, CH_DEL, 8'h00};
      5'd2:  e = '{KIND_BYTE, CH_HT, 8'h00};
      5'd3:  e = '{KIND_BYTE, CH_ESC, 8'h00};
      5'd4:  e = '{KIND_SHORT, CH_LBRK, 8'h41};
      5'd5:  e = '{KIND_SHORT, CH_LBRK, 8'h42};
      5'd6:  e = '{KIND_SHORT, CH_LBRK, 8'h43};
      5'd7:  e = '{KIND_SHORT, CH_LBRK, 8'h44};
      5'd8:  e = '{KIND_SHORT, CH_LBRK, 8'h48};
      5'd9:  e = '{KIND_SHORT, CH_LBRK, 8'h46};
      5'd10: e = '{KIND_NUMBER, 8'h00, 8'd2};
      5'd11: e = '{KIND_NUMBER, 8'h00, 8'd3};
      5'd12: e = '{KIND_NUMBER, 8'h00, 8'd5};
      5'd13: e = '{KIND_NUMBER, 8'h00, 8'd6};
      5'd14: e = '{KIND_SHORT, CH_SS3, 8'h50};
      5'd15: e = '{KIND_SHORT, CH_SS3, 8'h51};
      5'd16: e = '{KIND_SHORT, CH_SS3, 8'h52};
      5'd17: e = '{KIND_SHORT, CH_SS3, 8'h53};
      5'd18: e = '{KIND_NUMBER, 8'h00, 8'd15};
      5'd19: e = '{KIND_NUMBER, 8'h00, 8'd17};
      5'd20: e = '{KIND_NUMBER, 8'h00, 8'd18};
      5'd21: e = '{KIND_NUMBER, 8'h00, 8'd19};
      5'd22: e = '{KIND_NUMBER, 8'h00, 8'd20};
      5'd23: e = '{KIND_NUMBER, 8'h00, 8'd21};
      5'd24: e = '{KIND_NUMBER, 8'h00, 8'd23};
      5'd25: e = '{KIND_NUMBER, 8'h00, 8'd24};
      default: e = '{KIND_NONE, 8'h00, 8'h00};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

[hdl/kte_if.sv]
// Channel interfaces for the key to escape sequence encoder.
// Depends on nothing; one interface for key requests, one for output bytes.
`default_nettype none

interface kte_key_if;
  logic       valid;
  logic       ready;
  logic [4:0] key_code;
  logic       ctrl_held;
  logic       shift_held;
  logic       alt_held;

  modport source (output valid, key_code, ctrl_held, shift_held, alt_held, input ready);
  modport sink   (input valid, key_code, ctrl_held, shift_held, alt_held, output ready);
endinterface

interface kte_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

[hdl/kte_builder.sv]
// Combinational sequence builder: key code and modifiers to byte list.
// Depends on kte_pkg.
`default_nettype none

module kte_builder (
  input  wire logic [4:0]  key_code,
  input  wire logic        ctrl_held,
  input  wire logic        shift_held,
  input  wire logic        alt_held,
  output kte_pkg::seq_t    seq
);

  kte_pkg::key_entry_t ent;
  logic [3:0]          mod_num;
  logic [7:0]          mod_ch;
  logic [7:0]          tens_ch;
  logic [4:0]          ones_val;
  logic [7:0]          ones_ch;

  assign ent     = kte_pkg::key_lookup(key_code);
  // modifier number 1..8
  assign mod_num = 4'd1 + {3'b000, shift_held} + {2'b00, alt_held, 1'b0}
                 + {1'b0, ctrl_held, 2'b00};
  assign mod_ch  = kte_pkg::CH_ZERO + {4'b0000, mod_num};

  // key numbers stay below 30, so tens is 0, 1 or 2
  always_comb begin
    if (ent.b[4:0] >= 5'd20) begin
      tens_ch  = kte_pkg::CH_TWO;
      ones_val = ent.b[4:0] - 5'd20;
    end else if (ent.b[4:0] >= 5'd10) begin
      tens_ch  = kte_pkg::CH_ONE;
      ones_val = ent.b[4:0] - 5'd10;
    end else begin
      tens_ch  = kte_pkg::CH_ZERO;
      ones_val = ent.b[4:0];
    end
  end
  assign ones_ch = kte_pkg::CH_ZERO + {3'b000, ones_val};

  always_comb begin
    logic [kte_pkg::LEN_W-1:0] p;
    seq = '0;
    p   = '0;
    case (ent.kind)
      kte_pkg::KIND_BYTE: begin
        seq.bytes[0] = (key_code == kte_pkg::KEY_BACKSPACE && ctrl_held) ?
                       kte_pkg::CH_BS : ent.a;
        seq.len = kte_pkg::LEN_W'(1);
      end
      kte_pkg::KIND_SHORT: begin
        seq.bytes[0] = kte_pkg::CH_ESC;
        if (mod_num == 4'd1) begin
          seq.bytes[1] = ent.a;
          seq.bytes[2] = ent.b;
          seq.len      = kte_pkg::LEN_W'(3);
        end else begin
          seq.bytes[1] = kte_pkg::CH_LBRK;
          seq.bytes[2] = kte_pkg::CH_ONE;
          seq.bytes[3] = kte_pkg::CH_SEMI;
          seq.bytes[4] = mod_ch;
          seq.bytes[5] = ent.b;
          seq.len      = kte_pkg::LEN_W'(6);
        end
      end
      kte_pkg::KIND_NUMBER: begin
        seq.bytes[0] = kte_pkg::CH_ESC;
        seq.bytes[1] = kte_pkg::CH_LBRK;
        if (ent.b[4:0] >= 5'd10) begin
          seq.bytes[2] = tens_ch;
          seq.bytes[3] = ones_ch;
          p = kte_pkg::LEN_W'(4);
        end else begin
          seq.bytes[2] = ones_ch;
          p = kte_pkg::LEN_W'(3);
        end
        if (mod_num != 4'd1) begin
          seq.bytes[p] = kte_pkg::CH_SEMI;
          seq.bytes[kte_pkg::LEN_W'(p + 1'b1)] = mod_ch;
          p = kte_pkg::LEN_W'(p + 2'd2);
        end
        seq.bytes[p] = kte_pkg::CH_TILDE;
        seq.len = kte_pkg::LEN_W'(p + 1'b1);
      end
      default: begin
        seq = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/kte_serializer.sv]
// Sequence register and output register: shifts one byte per cycle out while the output is not stalled.
// Depends on kte_pkg.
`default_nettype none

module kte_serializer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kte_pkg::seq_t seq,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last
);

  logic [kte_pkg::SEQ_MAX-1:0][7:0] sq_bytes_r, sq_bytes_nxt;
  logic [kte_pkg::LEN_W-1:0]        sq_left_r, sq_left_nxt;
  logic                             out_valid_r;
  logic [7:0]                       out_byte_r;
  logic                             out_last_r;
  logic                             out_free;
  logic                             emit;
  logic                             take;

  assign out_free = !out_valid_r || out_ready;
  assign emit     = (sq_left_r != '0) && out_free;
  // next request loads while the final byte of the current one goes out
  assign in_ready = (sq_left_r == '0) ||
                    (sq_left_r == kte_pkg::LEN_W'(1) && emit);
  assign take     = in_valid && in_ready;

  always_comb begin
    sq_bytes_nxt = sq_bytes_r;
    sq_left_nxt  = sq_left_r;
    if (take) begin
      sq_bytes_nxt = seq.bytes;
      sq_left_nxt  = seq.len;
    end else if (emit) begin
      sq_bytes_nxt = {8'h00, sq_bytes_r[kte_pkg::SEQ_MAX-1:1]};
      sq_left_nxt  = sq_left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sq_bytes_r <= sq_bytes_nxt;
    if (emit) begin
      out_byte_r <= sq_bytes_r[0];
      out_last_r <= (sq_left_r == kte_pkg::LEN_W'(1));
    end
    if (!rst_n) begin
      sq_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sq_left_r <= sq_left_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  a_load_len: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> sq_left_r == $past(seq.len))
    else $error("sequence length not loaded on request");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && !take) |=> sq_left_r == $past(sq_left_r))
    else $error("sequence advanced while output stalled");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted byte not presented");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && sq_left_r == kte_pkg::LEN_W'(1) && !take) |=> sq_left_r == '0)
    else $error("sequence not empty after final byte");

endmodule

`default_nettype wire

[hdl/key_to_escape_sequence_encoder.sv]
// Top level of the key to escape sequence encoder.
// Depends on kte_pkg, kte_if, kte_builder and kte_serializer.
`default_nettype none

// Turns one special-key request (key code plus ctrl/shift/alt) into the
// xterm-style byte sequence for that key, one byte per output request,
// with last_byte set on the final byte. Enter/tab/escape give CR/HT/ESC,
// backspace gives DEL (BS with ctrl). Cursor keys, Home, End and F1-F4
// give ESC c0 c1, or ESC [ 1 ; m c1 when a modifier is held. Insert,
// Delete, PageUp, PageDown and F5-F12 give ESC [ n ~ or ESC [ n ; m ~,
// with m = 1 + shift + 2*alt + 4*ctrl. Codes 26..31 are accepted and
// produce nothing.
// Timing: the sequence is built combinationally at the input and loaded
// into a seven-byte shift register; one byte per cycle moves into the
// output register while the output is not stalled, so the first byte of
// a key passes the shift register and then the output register before
// it is presented. A known key has 1 to 7 bytes, sent on the single
// output byte lane; an unknown code is still taken. The next key is
// taken in the cycle its predecessor's last byte leaves the shift
// register, so sequences stream with no gap. Output stalls freeze the
// shift register and the output register; an empty shift register still
// takes one key during a stall. No registers to configure, no startup sweep.

module key_to_escape_sequence_encoder (
  input wire logic   clk,
  input wire logic   rst_n,
  kte_key_if.sink    in_key,
  kte_byte_if.source out_seq
);

  kte_pkg::seq_t seq;   // full byte list for the key at the input

  kte_builder u_builder (
    .key_code   (in_key.key_code),
    .ctrl_held  (in_key.ctrl_held),
    .shift_held (in_key.shift_held),
    .alt_held   (in_key.alt_held),
    .seq        (seq)
  );

  // shift register plus output register; ready comes from here
  kte_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .seq       (seq),
    .in_valid  (in_key.valid),
    .in_ready  (in_key.ready),
    .out_valid (out_seq.valid),
    .out_ready (out_seq.ready),
    .out_byte  (out_seq.out_byte),
    .out_last  (out_seq.last_byte)
  );

endmodule

`default_nettype wire
